@@ sv/cor_pkg.sv @@
// Shared types and constants for the midpoint circle rasteriser core.
// Used by cor_front, cor_queue, cor_back and circle_octant_rasterizer_core.
// No dependencies.
`timescale 1ns / 1ps

package cor_pkg;

  // Centre coordinate width held in the core
  localparam int COORD_WIDTH = 10;
  localparam int IN_COORD_W  = 10;
  localparam int RAD_W       = 9;
  localparam int DEC_W       = 13;
  localparam int PIX_W       = 12;
  localparam int COL_W       = 4;
  localparam int NUM_PTS     = 8;
  localparam int PT_IDX_W    = $clog2(NUM_PTS);
  // Step span: one more bit than the radius plus a sign bit
  localparam int SPAN_W      = RAD_W + 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef struct packed {
    logic                  operation;
    logic [IN_COORD_W-1:0] center_x;
    logic [IN_COORD_W-1:0] center_y;
    logic [RAD_W-1:0]      radius;
    logic [COL_W-1:0]      pen_color;
  } item_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic [COL_W-1:0]        pixel_color;
    logic                    run_last;
    logic                    circle_done;
  } pixel_t;

  // One step's worth of work: the octant position to be mirrored eight ways
  typedef struct packed {
    logic [COORD_WIDTH-1:0] cx;
    logic [COORD_WIDTH-1:0] cy;
    logic [RAD_W-1:0]       oi;
    logic [RAD_W-1:0]       oj;
    logic [COL_W-1:0]       colour;
    logic                   done;
  } job_t;

  // Front-to-queue write side
  typedef struct packed {
    logic push;
    job_t job;
  } qwr_t;

  // Queue-to-back read side
  typedef struct packed {
    logic valid;
    job_t job;
  } qrd_t;

endpackage

@@ sv/cor_front.sv @@
// Front end: accepts transactions, keeps the circle state and advances it.
// Each active step produces one job for the queue. Depends on cor_pkg.
`timescale 1ns / 1ps

module cor_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  cor_pkg::item_t item,
  input  logic           q_full,
  output cor_pkg::qwr_t  qwr
);

  logic [cor_pkg::COORD_WIDTH-1:0] centre_col;
  logic [cor_pkg::COORD_WIDTH-1:0] centre_row;
  logic [cor_pkg::RAD_W-1:0]       octant_i;
  logic [cor_pkg::RAD_W-1:0]       octant_j;
  logic [cor_pkg::DEC_W-1:0]       decision;
  logic [cor_pkg::COL_W-1:0]       draw_color;
  logic                            circle_active;

  logic                            accept;
  logic                            is_step;
  logic                            dec_neg;
  logic signed [cor_pkg::SPAN_W-1:0] ni;
  logic signed [cor_pkg::SPAN_W-1:0] nj;
  logic [cor_pkg::DEC_W-1:0]       np;
  logic [cor_pkg::DEC_W-1:0]       diff4;
  logic                            step_done;

  assign item_ready = !q_full;
  assign accept     = item_valid && item_ready;
  assign is_step    = (cor_pkg::op_t'(item.operation) == cor_pkg::OP_STEP);

  // Midpoint advance, using the old i and j
  always_comb begin
    dec_neg   = decision[cor_pkg::DEC_W-1];
    ni        = cor_pkg::SPAN_W'(octant_i) + cor_pkg::SPAN_W'(1);
    nj        = cor_pkg::SPAN_W'(octant_j) - (dec_neg ? cor_pkg::SPAN_W'(0)
                                                      : cor_pkg::SPAN_W'(1));
    step_done = ni > nj;
    diff4     = (cor_pkg::DEC_W'(octant_i) - cor_pkg::DEC_W'(octant_j)) << 2;
    if (dec_neg) begin
      np = decision + (cor_pkg::DEC_W'(octant_i) << 2) + cor_pkg::DEC_W'(6);
    end else begin
      np = decision + diff4 + cor_pkg::DEC_W'(10);
    end
  end

  // Job towards the back end
  always_comb begin
    qwr.push       = accept && is_step && circle_active;
    qwr.job.cx     = centre_col;
    qwr.job.cy     = centre_row;
    qwr.job.oi     = octant_i;
    qwr.job.oj     = octant_j;
    qwr.job.colour = draw_color;
    qwr.job.done   = step_done;
  end

  // Circle state
  always_ff @(posedge clk) begin
    if (rst) begin
      circle_active <= 1'b0;
    end else if (accept) begin
      if (!is_step) begin
        centre_col    <= cor_pkg::COORD_WIDTH'(item.center_x);
        centre_row    <= cor_pkg::COORD_WIDTH'(item.center_y);
        draw_color    <= item.pen_color;
        octant_i      <= '0;
        octant_j      <= item.radius;
        decision      <= cor_pkg::DEC_W'(3) - (cor_pkg::DEC_W'(item.radius) << 1);
        circle_active <= 1'b1;
      end else if (circle_active) begin
        octant_i <= ni[cor_pkg::RAD_W-1:0];
        octant_j <= nj[cor_pkg::RAD_W-1:0];
        decision <= np;
        if (step_done) begin
          circle_active <= 1'b0;
        end
      end
    end
  end

  // A job only comes from an accepted step while a circle runs
  a_push_src: assert property (@(posedge clk) disable iff (rst)
    qwr.push |-> (accept && is_step && circle_active))
    else $error("job pushed without an active step");

  // The finishing step closes the circle
  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    (qwr.push && qwr.job.done) |=> !circle_active)
    else $error("circle still active after its last step");

endmodule

@@ sv/cor_queue.sv @@
// Short job queue between the front and back ends.
// Depth set by cor_pkg::QUEUE_DEPTH. Depends on cor_pkg.
`timescale 1ns / 1ps

module cor_queue (
  input  logic          clk,
  input  logic          rst,
  input  cor_pkg::qwr_t qwr,
  output logic          full,
  output cor_pkg::qrd_t qrd,
  input  logic          pop
);

  cor_pkg::job_t               slots [cor_pkg::QUEUE_DEPTH];
  logic [cor_pkg::QPTR_W-1:0]  wr_ptr;
  logic [cor_pkg::QPTR_W-1:0]  rd_ptr;
  logic [cor_pkg::QCNT_W-1:0]  count;
  logic                        do_pop;

  assign full      = (count == cor_pkg::QCNT_W'(cor_pkg::QUEUE_DEPTH));
  assign qrd.valid = (count != '0);
  assign qrd.job   = slots[rd_ptr];
  assign do_pop    = pop && qrd.valid;

  // Storage
  always_ff @(posedge clk) begin
    if (qwr.push && !full) begin
      slots[wr_ptr] <= qwr.job;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (qwr.push && !full) begin
        wr_ptr <= (wr_ptr == cor_pkg::QPTR_W'(cor_pkg::QUEUE_DEPTH - 1))
                  ? '0 : wr_ptr + cor_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == cor_pkg::QPTR_W'(cor_pkg::QUEUE_DEPTH - 1))
                  ? '0 : rd_ptr + cor_pkg::QPTR_W'(1);
      end
      case ({qwr.push && !full, do_pop})
        2'b10:   count <= count + cor_pkg::QCNT_W'(1);
        2'b01:   count <= count - cor_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(qwr.push && full))
    else $error("job pushed into a full queue");

  a_level: assert property (@(posedge clk) disable iff (rst)
    count <= cor_pkg::QCNT_W'(cor_pkg::QUEUE_DEPTH))
    else $error("queue level out of range");

endmodule

@@ sv/cor_back.sv @@
// Back end: takes one job and plays out its eight mirrored points, one per
// cycle unless pixel_ready stalls it, through a registered output. Depends on cor_pkg.
`timescale 1ns / 1ps

module cor_back (
  input  logic            clk,
  input  logic            rst,
  input  cor_pkg::qrd_t   qrd,
  output logic            pop,
  output logic            pixel_valid,
  input  logic            pixel_ready,
  output cor_pkg::pixel_t pixel
);

  cor_pkg::job_t                 job;
  logic                          busy;
  logic [cor_pkg::PT_IDX_W-1:0]  cnt;
  logic                          advance;
  logic                          last_pt;
  logic [cor_pkg::RAD_W-1:0]     xa;
  logic [cor_pkg::RAD_W-1:0]     ya;
  logic                          xneg;
  logic                          yneg;
  logic [cor_pkg::PIX_W-1:0]     px;
  logic [cor_pkg::PIX_W-1:0]     py;

  assign advance = busy && (!pixel_valid || pixel_ready);
  assign last_pt = (cnt == cor_pkg::PT_IDX_W'(cor_pkg::NUM_PTS - 1));
  assign pop     = !busy || (advance && last_pt);

  // Octant mirror for the current point
  always_comb begin
    case (cnt)
      3'd0:    begin xa = job.oi; xneg = 1'b0; ya = job.oj; yneg = 1'b0; end
      3'd1:    begin xa = job.oi; xneg = 1'b1; ya = job.oj; yneg = 1'b1; end
      3'd2:    begin xa = job.oj; xneg = 1'b0; ya = job.oi; yneg = 1'b0; end
      3'd3:    begin xa = job.oj; xneg = 1'b1; ya = job.oi; yneg = 1'b1; end
      3'd4:    begin xa = job.oi; xneg = 1'b1; ya = job.oj; yneg = 1'b0; end
      3'd5:    begin xa = job.oi; xneg = 1'b0; ya = job.oj; yneg = 1'b1; end
      3'd6:    begin xa = job.oj; xneg = 1'b1; ya = job.oi; yneg = 1'b0; end
      default: begin xa = job.oj; xneg = 1'b0; ya = job.oi; yneg = 1'b1; end
    endcase
    px = xneg ? cor_pkg::PIX_W'(job.cx) - cor_pkg::PIX_W'(xa)
              : cor_pkg::PIX_W'(job.cx) + cor_pkg::PIX_W'(xa);
    py = yneg ? cor_pkg::PIX_W'(job.cy) - cor_pkg::PIX_W'(ya)
              : cor_pkg::PIX_W'(job.cy) + cor_pkg::PIX_W'(ya);
  end

  // Job register and point counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else begin
      if (advance) begin
        cnt <= last_pt ? '0 : cnt + cor_pkg::PT_IDX_W'(1);
      end
      if (pop) begin
        busy <= qrd.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && qrd.valid) begin
      job <= qrd.job;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (advance) begin
      pixel_valid <= 1'b1;
    end else if (pixel_ready) begin
      pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel.pixel_x     <= px;
      pixel.pixel_y     <= py;
      pixel.pixel_color <= job.colour;
      pixel.run_last    <= last_pt;
      pixel.circle_done <= last_pt && job.done;
    end
  end

  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && pixel.circle_done) |-> pixel.run_last)
    else $error("circle end flagged away from a step's last point");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (cnt == '0))
    else $error("point counter moved while idle");

endmodule

@@ sv/circle_octant_rasterizer_core.sv @@
// Top level of the midpoint circle rasteriser core.
// Instantiates cor_front, cor_queue and cor_back; depends on cor_pkg.
//
//   port group    dir  handshake                 payload
//   item          in   item_valid / item_ready   cor_pkg::item_t
//   pixel         out  pixel_valid / pixel_ready cor_pkg::pixel_t
//
// A start transaction gives no pixel. A step gives eight pixels, one per cycle
// unless pixel_ready holds them back; the back end's single point generator
// sets the sustained step rate. The front end accepts while the two-entry job
// queue has room, and stalls only when it is full.
// Reset (rst, synchronous) clears the circle, the queue and the output valid.
`timescale 1ns / 1ps

module circle_octant_rasterizer_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  cor_pkg::item_t  item,
  output logic            pixel_valid,
  input  logic            pixel_ready,
  output cor_pkg::pixel_t pixel
);

  cor_pkg::qwr_t qwr;
  cor_pkg::qrd_t qrd;
  logic          q_full;
  logic          q_pop;

  cor_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_full     (q_full),
    .qwr        (qwr)
  );

  cor_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .qwr  (qwr),
    .full (q_full),
    .qrd  (qrd),
    .pop  (q_pop)
  );

  cor_back u_back (
    .clk         (clk),
    .rst         (rst),
    .qrd         (qrd),
    .pop         (q_pop),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel)
  );

endmodule

@@ sim/circle_octant_rasterizer_core_test.sv @@
// Self-checking testbench for circle_octant_rasterizer_core: drives start and step
// transactions and checks every pixel against a midpoint circle predictor.
// Depends on cor_pkg and circle_octant_rasterizer_core.
`timescale 1ns / 1ps

import cor_pkg::*;

// Circle predictor plus the store of pixels still owed by the core
class pixel_scoreboard;
  pixel_t                    expected_pixels[$];
  int                        errors;
  int                        checked;
  bit                        active;
  logic [COORD_WIDTH-1:0]    ctr_col;
  logic [COORD_WIDTH-1:0]    ctr_row;
  logic [RAD_W-1:0]          oct_i;
  logic [RAD_W-1:0]          oct_j;
  logic signed [DEC_W-1:0]   decision;
  logic [COL_W-1:0]          colour;

  function new();
    errors   = 0;
    checked  = 0;
    active   = 1'b0;
    ctr_col  = '0;
    ctr_row  = '0;
    oct_i    = '0;
    oct_j    = '0;
    decision = '0;
    colour   = '0;
  endfunction

  task report_mismatch(string msg);
    errors++;
    if (errors <= 100) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  function void push_point(int px, int py, bit last, bit fin);
    pixel_t pt;
    pt.pixel_x     = px[PIX_W-1:0];
    pt.pixel_y     = py[PIX_W-1:0];
    pt.pixel_color = colour;
    pt.run_last    = last;
    pt.circle_done = fin;
    expected_pixels.push_back(pt);
  endfunction

  // Rasterise one accepted transaction; returns the number of pixels it owes
  function int rasterise_item(item_t it);
    int i, j, p, ni, nj, np, cx, cy;
    bit fin;
    if (it.operation == OP_START) begin
      ctr_col  = it.center_x;
      ctr_row  = it.center_y;
      colour   = it.pen_color;
      oct_i    = '0;
      oct_j    = it.radius;
      decision = DEC_W'(3 - 2 * int'(it.radius));
      active   = 1'b1;
      return 0;
    end
    // a step with no circle running is dropped
    if (!active) return 0;
    cx = int'(ctr_col);
    cy = int'(ctr_row);
    i  = int'(oct_i);
    j  = int'(oct_j);
    p  = int'(decision);
    // midpoint advance from the old position
    if (p < 0) begin
      np = p + 4 * i + 6;
      ni = i + 1;
      nj = j;
    end else begin
      np = p + 4 * (i - j) + 10;
      ni = i + 1;
      nj = j - 1;
    end
    fin = (ni > nj);
    push_point(cx + i, cy + j, 1'b0, 1'b0);
    push_point(cx - i, cy - j, 1'b0, 1'b0);
    push_point(cx + j, cy + i, 1'b0, 1'b0);
    push_point(cx - j, cy - i, 1'b0, 1'b0);
    push_point(cx - i, cy + j, 1'b0, 1'b0);
    push_point(cx + i, cy - j, 1'b0, 1'b0);
    push_point(cx - j, cy + i, 1'b0, 1'b0);
    push_point(cx + j, cy - i, 1'b1, fin);
    oct_i    = ni[RAD_W-1:0];
    oct_j    = nj[RAD_W-1:0];
    decision = np[DEC_W-1:0];
    if (fin) active = 1'b0;
    return NUM_PTS;
  endfunction

  // Compare one accepted pixel with the oldest one owed
  task check_pixel(pixel_t got);
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      report_mismatch($sformatf("unexpected pixel x=%0d y=%0d", got.pixel_x, got.pixel_y));
      return;
    end
    want = expected_pixels.pop_front();
    if (got.pixel_x !== want.pixel_x)
      report_mismatch($sformatf("pixel %0d: pixel_x %0d, want %0d",
                                checked, got.pixel_x, want.pixel_x));
    if (got.pixel_y !== want.pixel_y)
      report_mismatch($sformatf("pixel %0d: pixel_y %0d, want %0d",
                                checked, got.pixel_y, want.pixel_y));
    if (got.pixel_color !== want.pixel_color)
      report_mismatch($sformatf("pixel %0d: pixel_color %0d, want %0d",
                                checked, got.pixel_color, want.pixel_color));
    if (got.run_last !== want.run_last)
      report_mismatch($sformatf("pixel %0d: run_last %b, want %b",
                                checked, got.run_last, want.run_last));
    if (got.circle_done !== want.circle_done)
      report_mismatch($sformatf("pixel %0d: circle_done %b, want %b",
                                checked, got.circle_done, want.circle_done));
    checked++;
  endtask
endclass

module circle_octant_rasterizer_core_test;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   item_valid = 1'b0;
  logic   item_ready;
  item_t  item = '0;
  logic   pixel_valid;
  logic   pixel_ready = 1'b0;
  pixel_t pixel;

  int send_idle_pct  = 34;
  int ready_idle_pct = 86;

  pixel_scoreboard sb;

  circle_octant_rasterizer_core dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel)
  );

  always #5 clk = ~clk;

  // Run limit, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("circle_octant_rasterizer_core verification failed");
    $finish;
  end

  // Pixel side back-pressure
  always @(negedge clk) begin
    pixel_ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= ready_idle_pct);
  end

  // Pixel transactions are checked at the edge that accepts them
  always @(posedge clk) begin
    if (!rst && pixel_valid && pixel_ready) sb.check_pixel(pixel);
  end

  function automatic item_t make_item(op_t op, int cx, int cy, int r, int col);
    item_t it;
    it.operation = op;
    it.center_x  = cx[IN_COORD_W-1:0];
    it.center_y  = cy[IN_COORD_W-1:0];
    it.radius    = r[RAD_W-1:0];
    it.pen_color = col[COL_W-1:0];
    return it;
  endfunction

  function automatic item_t random_item(op_t op);
    return make_item(op, $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 511), $urandom_range(0, 15));
  endfunction

  // Present one transaction, holding it until accepted; entered and left at a falling edge
  task automatic send_item(item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    void'(sb.rasterise_item(it));
    @(negedge clk);
  endtask

  task automatic send_step();
    send_item(random_item(OP_STEP));
  endtask

  // Corners, zero and full radius, dropped circles and steps with nothing running
  task automatic run_directed();
    send_item(make_item(OP_STEP, 0, 0, 0, 0));
    send_item(make_item(OP_START, 0, 0, 0, 15));
    send_step();
    send_step();
    send_item(make_item(OP_START, 1023, 1023, 511, 0));
    repeat (3) send_step();
    send_item(make_item(OP_START, 0, 1023, 1, 5));
    repeat (2) send_step();
    send_item(make_item(OP_START, 1023, 0, 3, 9));
    repeat (3) send_step();
    send_item(make_item(OP_START, 'h2AA, 'h155, 'h155, 'hA));
    repeat (2) send_step();
    send_item(make_item(OP_START, 'h155, 'h2AA, 'hAA, 'h5));
    repeat (2) send_step();
  endtask

  // Mostly whole circles with random content, some cut short by a new start
  task automatic run_random(int target);
    int    counted;
    int    pick;
    int    limit;
    int    extra;
    int    n;
    item_t st;
    counted = 0;
    while (counted < target) begin
      st   = random_item(OP_START);
      pick = $urandom_range(0, 99);
      if (pick < 8)       st.radius = $urandom_range(256, 511);
      else if (pick < 22) st.radius = $urandom_range(0, 3);
      else                st.radius = $urandom_range(4, 60);
      send_item(st);
      counted++;
      limit = (pick < 8 || $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 1000;
      extra = $urandom_range(0, 2);
      n = 0;
      while (n < limit && sb.active && counted < target) begin
        send_step();
        n++;
        counted++;
      end
      if (!sb.active) begin
        repeat (extra) send_step();
        counted += extra;
      end
    end
  endtask

  initial begin
    int waited;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();
    run_random(96);

    send_idle_pct  = 86;
    ready_idle_pct = 34;
    run_random(96);

    send_idle_pct  = 0;
    ready_idle_pct = 0;
    run_random(97);
    item_valid <= 1'b0;

    // drain, then watch a while for stray pixels
    waited = 0;
    while (sb.expected_pixels.size() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (sb.expected_pixels.size() != 0)
      sb.report_mismatch($sformatf("%0d pixels never arrived", sb.expected_pixels.size()));

    if (sb.errors == 0) begin
      $display("circle_octant_rasterizer_core verification clean");
    end else begin
      $display("circle_octant_rasterizer_core verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/cor_pkg.sv
sv/cor_front.sv
sv/cor_queue.sv
sv/cor_back.sv
sv/circle_octant_rasterizer_core.sv
sim/circle_octant_rasterizer_core_test.sv
